[rtl/core/call_trace_recorder_defines.svh]
// ----------------------------------------------------------------------------
// Call trace recorder assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef CALL_TRACE_RECORDER_DEFINES_SVH
`define CALL_TRACE_RECORDER_DEFINES_SVH

// same-cycle implication
`define CTR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ctr_pkg.sv]
// ----------------------------------------------------------------------------
// Call trace recorder package
// Widths, request and status codes, controller command and status structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctr_pkg;

  localparam int DEPTH_W   = 7;
  localparam int PC_W      = 56;
  localparam int WORD_W    = 64;
  localparam int IDX_W     = 20;
  localparam int BUF_W     = 21;
  localparam int FREQ_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int LEVEL_W   = 8;
  localparam int NS_W      = 30;
  localparam int HALF_W    = 32;
  localparam int MUL_W     = HALF_W + NS_W;
  localparam int PROD_W    = WORD_W + NS_W;
  localparam int CNT_W     = 6;

  localparam logic [NS_W-1:0]  NS_PER_S  = 30'd1000000000;
  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd56;

  localparam logic [1:0] REQ_ENTER  = 2'd0;
  localparam logic [1:0] REQ_RETURN = 2'd1;
  localparam logic [1:0] REQ_UNWIND = 2'd2;
  localparam logic [1:0] REQ_BAD    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DEPTH   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_WORDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ      = 2'd2;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LATCH    = 4'd1;
  localparam logic [3:0] OP_EMPTY    = 4'd2;
  localparam logic [3:0] OP_ENTER    = 4'd3;
  localparam logic [3:0] OP_POP      = 4'd4;
  localparam logic [3:0] OP_DELTA    = 4'd5;
  localparam logic [3:0] OP_MUL_LO   = 4'd6;
  localparam logic [3:0] OP_MUL_HI   = 4'd7;
  localparam logic [3:0] OP_SUM      = 4'd8;
  localparam logic [3:0] OP_DIV_INIT = 4'd9;
  localparam logic [3:0] OP_DIV_STEP = 4'd10;
  localparam logic [3:0] OP_RET_WR   = 4'd11;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] status;
  } ctr_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       enabled;
    logic       depth_zero;
    logic       above_target;
    logic       div_busy;
    logic       out_free;
  } ctr_sts_t;

endpackage

[rtl/core/ctr_in_if.sv]
// ----------------------------------------------------------------------------
// Call trace request channel
// Valid/ready channel carrying one trace request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ctr_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [ctr_pkg::PC_W-1:0]  pc;
  logic [ctr_pkg::WORD_W-1:0] return_addr_in;
  logic [ctr_pkg::WORD_W-1:0] timestamp;
  logic [ctr_pkg::DEPTH_W-1:0] target_depth;

  modport source(output valid, req_type, pc, return_addr_in, timestamp, target_depth,
                 input ready);
  modport sink(input valid, req_type, pc, return_addr_in, timestamp, target_depth,
               output ready);
endinterface

[rtl/core/ctr_out_if.sv]
// ----------------------------------------------------------------------------
// Call trace result channel
// Valid/ready channel carrying one trace result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ctr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        write_en;
  logic [ctr_pkg::IDX_W-1:0]   write_index;
  logic [ctr_pkg::WORD_W-1:0]  write_word;
  logic [ctr_pkg::WORD_W-1:0]  return_addr;
  logic                        hooked;
  logic [ctr_pkg::DEPTH_W-1:0] depth;
  logic                        overflowed;
  logic [1:0]                  status;
  logic                        last;

  modport source(output valid, write_en, write_index, write_word, return_addr, hooked,
                 depth, overflowed, status, last, input ready);
  modport sink(input valid, write_en, write_index, write_word, return_addr, hooked,
               depth, overflowed, status, last, output ready);
endinterface

[rtl/core/ctr_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ctr_ctl.sv]
// ----------------------------------------------------------------------------
// Call trace controller
// Sequences decode, frame pop, elapsed time multiply/divide and result write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctr_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ctr_pkg::ctr_sts_t sts,
  output ctr_pkg::ctr_cmd_t cmd
);
  import ctr_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_READ     = 4'd2;
  localparam logic [3:0] S_MUL_LO   = 4'd3;
  localparam logic [3:0] S_MUL_HI   = 4'd4;
  localparam logic [3:0] S_SUM      = 4'd5;
  localparam logic [3:0] S_DIV_INIT = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_RET_WR   = 4'd8;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.status = ST_OK;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.out_free) begin
          if (!sts.enabled || sts.req == REQ_BAD) begin
            cmd.op     = OP_EMPTY;
            cmd.status = ST_INVALID;
            state_next = S_IDLE;
          end else if (sts.req == REQ_ENTER) begin
            cmd.op     = OP_ENTER;
            state_next = S_IDLE;
          end else if (sts.req == REQ_RETURN && sts.depth_zero) begin
            cmd.op     = OP_EMPTY;
            cmd.status = ST_INVALID;
            state_next = S_IDLE;
          end else if (sts.req == REQ_UNWIND && !sts.above_target) begin
            cmd.op     = OP_EMPTY;
            state_next = S_IDLE;
          end else begin
            cmd.op     = OP_POP;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.op     = OP_DELTA;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op     = OP_MUL_LO;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op     = OP_MUL_HI;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_busy) begin
          cmd.op = OP_DIV_STEP;
        end else begin
          state_next = S_RET_WR;
        end
      end
      S_RET_WR: begin
        if (sts.out_free) begin
          cmd.op = OP_RET_WR;
          // unwind keeps popping while above target
          state_next = (sts.req == REQ_UNWIND && sts.above_target) ? S_DECODE : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/ctr_dp.sv]
// ----------------------------------------------------------------------------
// Call trace datapath
// Config, call stack, ring index, elapsed time unit and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctr_dp #(
  parameter int MAX_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ctr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctr_pkg::CFG_W-1:0]    cfg_data,
  input  logic [1:0]                   req_type,
  input  logic [ctr_pkg::PC_W-1:0]     pc,
  input  logic [ctr_pkg::WORD_W-1:0]   return_addr_in,
  input  logic [ctr_pkg::WORD_W-1:0]   timestamp,
  input  logic [ctr_pkg::DEPTH_W-1:0]  target_depth,
  input  ctr_pkg::ctr_cmd_t            cmd,
  output ctr_pkg::ctr_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         write_en,
  output logic [ctr_pkg::IDX_W-1:0]    write_index,
  output logic [ctr_pkg::WORD_W-1:0]   write_word,
  output logic [ctr_pkg::WORD_W-1:0]   return_addr,
  output logic                         hooked,
  output logic [ctr_pkg::DEPTH_W-1:0]  depth,
  output logic                         overflowed,
  output logic [1:0]                   status,
  output logic                         last
);
  import ctr_pkg::*;

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int FRAME_W = 2 * WORD_W;

  // configuration
  logic              trace_enable;
  logic [BUF_W-1:0]  buf_words;
  logic [FREQ_W-1:0] counter_freq;

  // architectural state
  logic [DEPTH_W-1:0] call_depth;
  logic [IDX_W-1:0]   ring_index;
  logic               overflow_flag;

  // latched request
  logic [1:0]         req_q;
  logic [PC_W-1:0]    pc_q;
  logic [WORD_W-1:0]  lr_q;
  logic [WORD_W-1:0]  now_q;
  logic [DEPTH_W-1:0] target_q;

  // elapsed time unit
  logic [WORD_W-1:0] delta;
  logic [WORD_W-1:0] ret_q;
  logic [MUL_W-1:0]  mul_res;
  logic [MUL_W-1:0]  prod_lo;
  logic [PROD_W-1:0] product;
  logic [PC_W-1:0]   div_sr;
  logic [FREQ_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [HALF_W-1:0] mul_a;
  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   trial_diff;
  logic              trial_ge;

  // stack
  logic [FRAME_W-1:0] frame_rd;
  logic               push_en;
  logic               depth_full;

  // ring
  logic [IDX_W-1:0] idx_sel;
  logic [BUF_W-1:0] idx_inc;
  logic             wrap;

  logic out_load;

  assign depth_full = call_depth >= DEPTH_W'(MAX_DEPTH);
  assign push_en    = (cmd.op == OP_ENTER) && !depth_full;

  ctr_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push_en),
    .waddr (call_depth[AW-1:0]),
    .wdata ({lr_q, now_q}),
    .re    (cmd.op == OP_POP),
    .raddr (AW'(call_depth - 1'b1)),
    .rdata (frame_rd)
  );

  // a stale index beyond a shrunken buffer restarts at zero
  assign idx_sel = ({1'b0, ring_index} < buf_words) ? ring_index : '0;
  assign idx_inc = {1'b0, idx_sel} + 1'b1;
  assign wrap    = idx_inc >= buf_words;

  assign mul_a      = (cmd.op == OP_MUL_LO) ? delta[HALF_W-1:0] : delta[WORD_W-1:HALF_W];
  assign trial      = {rem, div_sr[PC_W-1]};
  assign trial_diff = trial - {1'b0, counter_freq};
  assign trial_ge   = trial >= {1'b0, counter_freq};

  assign sts.req          = req_q;
  assign sts.enabled      = trace_enable && (buf_words != '0);
  assign sts.depth_zero   = call_depth == '0;
  assign sts.above_target = call_depth > target_q;
  assign sts.div_busy     = cnt != '0;
  assign sts.out_free     = !out_valid || out_ready;

  assign out_load = (cmd.op == OP_EMPTY) || (cmd.op == OP_ENTER) || (cmd.op == OP_RET_WR);

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_enable  <= 1'b0;
      buf_words     <= '0;
      counter_freq  <= FREQ_W'(1);
      call_depth    <= '0;
      ring_index    <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE:    trace_enable <= cfg_data[0];
          CFG_BUF_WORDS: buf_words    <= cfg_data[BUF_W-1:0];
          CFG_FREQ:      counter_freq <= cfg_data[FREQ_W-1:0];
          default: begin
          end
        endcase
      end

      if (push_en) begin
        call_depth <= call_depth + 1'b1;
      end else if (cmd.op == OP_POP) begin
        call_depth <= call_depth - 1'b1;
      end

      if (cmd.op == OP_ENTER || cmd.op == OP_RET_WR) begin
        ring_index <= wrap ? '0 : idx_inc[IDX_W-1:0];
        if (wrap) begin
          overflow_flag <= 1'b1;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.op == OP_DIV_INIT) begin
        // quotient of 2^56 or more saturates; freq zero lands here too
        if (product[PROD_W-1:PC_W] >= {{(PROD_W-PC_W-FREQ_W){1'b0}}, counter_freq}) begin
          cnt <= '0;
        end else begin
          cnt <= DIV_STEPS;
        end
      end else if (cmd.op == OP_DIV_STEP) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      req_q    <= req_type;
      pc_q     <= pc;
      lr_q     <= return_addr_in;
      now_q    <= timestamp;
      target_q <= target_depth;
    end

    unique case (cmd.op)
      OP_DELTA: begin
        delta <= now_q - frame_rd[WORD_W-1:0];
        ret_q <= frame_rd[FRAME_W-1:WORD_W];
      end
      OP_MUL_LO: begin
        mul_res <= mul_a * NS_PER_S;
      end
      OP_MUL_HI: begin
        prod_lo <= mul_res;
        mul_res <= mul_a * NS_PER_S;
      end
      OP_SUM: begin
        product <= {mul_res, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, prod_lo};
      end
      OP_DIV_INIT: begin
        if (product[PROD_W-1:PC_W] >= {{(PROD_W-PC_W-FREQ_W){1'b0}}, counter_freq}) begin
          div_sr <= '1;
        end else begin
          rem    <= product[PC_W+FREQ_W-1:PC_W];
          div_sr <= product[PC_W-1:0];
        end
      end
      OP_DIV_STEP: begin
        rem    <= trial_ge ? trial_diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
        div_sr <= {div_sr[PC_W-2:0], trial_ge};
      end
      default: begin
      end
    endcase

    unique case (cmd.op)
      OP_EMPTY: begin
        write_en    <= 1'b0;
        write_index <= '0;
        write_word  <= '0;
        return_addr <= '0;
        hooked      <= 1'b0;
        depth       <= call_depth;
        overflowed  <= overflow_flag;
        status      <= cmd.status;
        last        <= 1'b1;
      end
      OP_ENTER: begin
        write_en    <= 1'b1;
        write_index <= idx_sel;
        write_word  <= {LEVEL_W'(call_depth) + 1'b1, pc_q};
        return_addr <= '0;
        hooked      <= !depth_full;
        depth       <= depth_full ? call_depth : call_depth + 1'b1;
        overflowed  <= overflow_flag || wrap;
        status      <= depth_full ? ST_DEPTH : ST_OK;
        last        <= 1'b1;
      end
      OP_RET_WR: begin
        write_en    <= 1'b1;
        write_index <= idx_sel;
        write_word  <= {{LEVEL_W{1'b0}}, div_sr};
        return_addr <= ret_q;
        hooked      <= 1'b0;
        depth       <= call_depth;
        overflowed  <= overflow_flag || wrap;
        status      <= ST_OK;
        last        <= (req_q != REQ_UNWIND) || !sts.above_target;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/call_trace_recorder.sv]
// ----------------------------------------------------------------------------
// Call trace recorder
// Function-graph tracer with a return-address stack and ring buffer writes.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (enter, return, unwind); results leave on out_ch,
// both valid/ready. Registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// An enter or a rejected request has its result loaded into the output register
// in the decode state once that register is free; the controller then returns to idle.
// Each pop (return, or each step of an unwind) runs a frame read from the stack
// RAM, two 32x30 partial products for the ns scale, a sum, then a 56-step
// restoring divide by counter_freq, one quotient bit per cycle.
// A saturating elapsed time skips the divide steps.
// One request is worked at a time; in_ch.ready is high only when idle.
// If out_ch stalls, the next result waits in the controller until the
// output register frees; nothing is dropped.
// Reset clears depth, ring index, overflow, config (freq back to 1) and the
// result valid; stack contents are only read after being pushed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "call_trace_recorder_defines.svh"

module call_trace_recorder #(
  parameter int MAX_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ctr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctr_pkg::CFG_W-1:0]     cfg_data,
  ctr_in_if.sink                        in_ch,
  ctr_out_if.source                     out_ch
);
  import ctr_pkg::*;

  ctr_cmd_t cmd;
  ctr_sts_t sts;

  ctr_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctr_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (in_ch.req_type),
    .pc             (in_ch.pc),
    .return_addr_in (in_ch.return_addr_in),
    .timestamp      (in_ch.timestamp),
    .target_depth   (in_ch.target_depth),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .write_en       (out_ch.write_en),
    .write_index    (out_ch.write_index),
    .write_word     (out_ch.write_word),
    .return_addr    (out_ch.return_addr),
    .hooked         (out_ch.hooked),
    .depth          (out_ch.depth),
    .overflowed     (out_ch.overflowed),
    .status         (out_ch.status),
    .last           (out_ch.last)
  );

  `CTR_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after accept")
  `CTR_ASSERT_IMP(a_depth_err, out_ch.valid && out_ch.status == ST_DEPTH, out_ch.write_en && out_ch.depth == DEPTH_W'(MAX_DEPTH), "depth error without full stack")
  `CTR_ASSERT_IMP(a_hooked, out_ch.valid && out_ch.hooked, out_ch.depth != '0 && out_ch.status == ST_OK && out_ch.write_en, "hooked result inconsistent")
  `CTR_ASSERT_IMP(a_no_write, out_ch.valid && !out_ch.write_en, out_ch.write_index == '0 && out_ch.write_word == '0 && out_ch.last, "empty result not clean")

endmodule

[tb/sv/call_trace_recorder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Call trace recorder testbench
// Drives enter, return and unwind requests under changing register settings,
// predicts every trace result in a behavioral model of the tracer and checks
// each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module call_trace_recorder_tb;
  import ctr_pkg::*;

  localparam int                STACK_DEPTH = 32;
  localparam logic [63:0]       NS_MASK     = 64'h00FF_FFFF_FFFF_FFFF;
  localparam logic [63:0]       NS_SCALE    = 64'd1000000000;

  typedef struct packed {
    logic             write_en;
    logic [IDX_W-1:0] write_index;
    logic [63:0]      write_word;
    logic [63:0]      return_addr;
    logic             hooked;
    logic [6:0]       depth;
    logic             overflowed;
    logic [1:0]       status;
    logic             last;
  } trace_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ctr_in_if  in_ch();
  ctr_out_if out_ch();

  call_trace_recorder u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // tracer model state
  logic        trc_enable;
  logic [20:0] trc_buf_words;
  logic [31:0] trc_freq;
  logic [6:0]  trc_depth;
  logic [63:0] saved_ret[STACK_DEPTH];
  logic [63:0] saved_start[STACK_DEPTH];
  logic [19:0] trc_ring;
  logic        trc_ovf;

  trace_result_t pending_results[$];
  int errors;
  int n_requests;
  int n_checked;
  int n_writes;
  int burst_left;
  int hold_cycles;
  int stall_cyc;
  logic [63:0] now_ts;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("tb: mismatch %s got %h want %h (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  function automatic logic [63:0] elapsed_ns(input logic [63:0] delta);
    logic [127:0] prod;
    logic [127:0] quot;
    if (trc_freq == 32'd0) return NS_MASK;
    prod = {64'd0, delta} * {64'd0, NS_SCALE};
    quot = prod / {96'd0, trc_freq};
    return (quot > {64'd0, NS_MASK}) ? NS_MASK : quot[63:0];
  endfunction

  function automatic void ring_write(input logic [63:0] word, inout trace_result_t r);
    logic [20:0] idx;
    idx = ({1'b0, trc_ring} < trc_buf_words) ? {1'b0, trc_ring} : 21'd0;
    r.write_en    = 1'b1;
    r.write_index = idx[19:0];
    r.write_word  = word;
    idx = idx + 21'd1;
    if (idx >= trc_buf_words) begin
      idx = 21'd0;
      trc_ovf = 1'b1;
    end
    trc_ring = idx[19:0];
  endfunction

  function automatic trace_result_t blank_result(input logic [1:0] st);
    trace_result_t r;
    r = '0;
    r.depth = trc_depth;
    r.overflowed = trc_ovf;
    r.status = st;
    return r;
  endfunction

  function automatic trace_result_t pop_frame(input logic [63:0] ts);
    trace_result_t r;
    r = '0;
    trc_depth = trc_depth - 7'd1;
    ring_write(elapsed_ns(ts - saved_start[trc_depth]), r);
    r.return_addr = saved_ret[trc_depth];
    r.depth = trc_depth;
    r.overflowed = trc_ovf;
    r.status = ST_OK;
    return r;
  endfunction

  // queues every result one request causes
  function automatic void predict_trace(input logic [1:0] kind, input logic [55:0] pc,
                                        input logic [63:0] ra, input logic [63:0] ts,
                                        input logic [6:0] tgt);
    trace_result_t r;
    trace_result_t outs[$];
    if (!trc_enable || trc_buf_words == 21'd0 || kind == REQ_BAD) begin
      outs.push_back(blank_result(ST_INVALID));
    end else if (kind == REQ_ENTER) begin
      r = '0;
      ring_write({trc_depth + 8'd1, pc}, r);
      if (trc_depth < STACK_DEPTH) begin
        saved_ret[trc_depth] = ra;
        saved_start[trc_depth] = ts;
        trc_depth = trc_depth + 7'd1;
        r.hooked = 1'b1;
        r.status = ST_OK;
      end else begin
        r.status = ST_DEPTH;
      end
      r.depth = trc_depth;
      r.overflowed = trc_ovf;
      outs.push_back(r);
    end else if (kind == REQ_RETURN) begin
      if (trc_depth == 7'd0) outs.push_back(blank_result(ST_INVALID));
      else outs.push_back(pop_frame(ts));
    end else begin
      while (trc_depth > tgt && trc_depth > 7'd0) outs.push_back(pop_frame(ts));
      if (outs.size() == 0) outs.push_back(blank_result(ST_OK));
    end
    outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) begin
      if (outs[i].write_en) n_writes++;
      pending_results.push_back(outs[i]);
    end
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ENABLE) trc_enable = val[0];
    else if (idx == CFG_BUF_WORDS) trc_buf_words = val[20:0];
    else if (idx == CFG_FREQ) trc_freq = val;
    @(posedge clk);
  endtask

  task automatic send_req(input logic [1:0] kind, input logic [55:0] pc,
                          input logic [63:0] ra, input logic [63:0] ts,
                          input logic [6:0] tgt);
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= kind;
    in_ch.pc             <= pc;
    in_ch.return_addr_in <= ra;
    in_ch.timestamp      <= ts;
    in_ch.target_depth   <= tgt;
    do @(posedge clk); while (!in_ch.ready);
    predict_trace(kind, pc, ra, ts, tgt);
    n_requests++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  // lets all outstanding results drain before touching registers
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic rand_req();
    int pick;
    logic [1:0] kind;
    logic [6:0] tgt;
    pick = $urandom_range(0, 99);
    if (pick < 4) kind = REQ_BAD;
    else if (pick < (trc_depth < 6 ? 60 : 45)) kind = REQ_ENTER;
    else if (pick < 85) kind = REQ_RETURN;
    else kind = REQ_UNWIND;
    tgt = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                      : 7'($urandom_range(0, trc_depth));
    if ($urandom_range(0, 15) == 0) now_ts = rand64();
    else now_ts = now_ts + $urandom_range(1, 200000);
    send_req(kind, rand64(), rand64(), now_ts, tgt);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    trace_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'd1, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.write_en != want.write_en) report("write_en", out_ch.write_en, want.write_en);
        if (out_ch.write_index != want.write_index)
          report("write_index", out_ch.write_index, want.write_index);
        if (out_ch.write_word != want.write_word)
          report("write_word", out_ch.write_word, want.write_word);
        if (out_ch.return_addr != want.return_addr)
          report("return_addr", out_ch.return_addr, want.return_addr);
        if (out_ch.hooked != want.hooked) report("hooked", out_ch.hooked, want.hooked);
        if (out_ch.depth != want.depth) report("depth", out_ch.depth, want.depth);
        if (out_ch.overflowed != want.overflowed)
          report("overflowed", out_ch.overflowed, want.overflowed);
        if (out_ch.status != want.status) report("status", out_ch.status, want.status);
        if (out_ch.last != want.last) report("last", out_ch.last, want.last);
      end
      n_checked++;
    end
    stall_cyc++;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      case ((stall_cyc / 97) % 3)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic test_disabled();
    send_req(REQ_ENTER, '1, '1, 64'd5, 7'd0);
    send_req(REQ_RETURN, '0, '0, 64'd6, 7'd0);
    send_req(REQ_UNWIND, '0, '0, 64'd7, 7'd0);
    wait_idle();
    cfg_write(CFG_ENABLE, 32'd1);
    send_req(REQ_ENTER, 56'h12345, 64'h1, 64'd8, 7'd0);
    wait_idle();
  endtask

  task automatic test_directed();
    cfg_write(CFG_BUF_WORDS, 32'd4);
    cfg_write(CFG_FREQ, 32'd1000000000);
    send_req(REQ_RETURN, '0, '0, 64'd10, 7'd0);
    send_req(REQ_UNWIND, '0, '0, 64'd10, 7'd0);
    send_req(REQ_ENTER, '0, '0, '0, 7'd0);
    send_req(REQ_ENTER, '1, '1, '1, 7'd0);
    send_req(REQ_ENTER, 56'h00AB_CDEF, 64'hDEAD_BEEF_0000_0001, 64'd100, 7'd0);
    send_req(REQ_RETURN, '0, '0, 64'd250, 7'd0);
    // wrapped counter: start was all ones
    send_req(REQ_RETURN, '0, '0, 64'd3, 7'd0);
    send_req(REQ_BAD, '1, '1, '1, '1);
    send_req(REQ_ENTER, 56'h1, 64'h2, 64'd0, 7'd0);
    send_req(REQ_ENTER, 56'h3, 64'h4, 64'd50, 7'd0);
    send_req(REQ_UNWIND, '0, '0, 64'd900, 7'd64);
    send_req(REQ_UNWIND, '0, '0, 64'd900, 7'd127);
    send_req(REQ_UNWIND, '0, '0, 64'd1000, 7'd0);
    wait_idle();
    // saturation and division extremes
    cfg_write(CFG_FREQ, 32'd1);
    send_req(REQ_ENTER, 56'h77, 64'h88, 64'd0, 7'd0);
    send_req(REQ_RETURN, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    wait_idle();
    cfg_write(CFG_FREQ, 32'd0);
    send_req(REQ_ENTER, 56'h77, 64'h88, 64'd0, 7'd0);
    send_req(REQ_RETURN, '0, '0, 64'd1, 7'd0);
    wait_idle();
    cfg_write(CFG_FREQ, 32'hFFFF_FFFF);
    send_req(REQ_ENTER, 56'h99, 64'hAA, 64'd0, 7'd0);
    send_req(REQ_RETURN, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    wait_idle();
  endtask

  task automatic test_full_depth();
    cfg_write(CFG_BUF_WORDS, 32'd1048576);
    cfg_write(CFG_FREQ, 32'd24000000);
    for (int i = 0; i <= STACK_DEPTH; i++)
      send_req(REQ_ENTER, 56'(i * 16), rand64(), 64'(i * 1000), 7'd0);
    send_req(REQ_UNWIND, '0, '0, 64'd500000, 7'd0);
    wait_idle();
  endtask

  task automatic test_shrunk_ring();
    cfg_write(CFG_BUF_WORDS, 32'd9);
    for (int i = 0; i < 6; i++) send_req(REQ_ENTER, 56'(i), 64'(i), 64'(i), 7'd0);
    wait_idle();
    // ring index now beyond the buffer
    cfg_write(CFG_BUF_WORDS, 32'd3);
    send_req(REQ_UNWIND, '0, '0, 64'd40, 7'd2);
    wait_idle();
    cfg_write(CFG_BUF_WORDS, 32'd1);
    send_req(REQ_UNWIND, '0, '0, 64'd80, 7'd0);
    wait_idle();
  endtask

  task automatic test_random();
    logic [31:0] freqs[4];
    freqs = '{32'd1, 32'd1000000000, 32'd19200000, 32'hFFFF_FFFF};
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(CFG_FREQ, (ph == 4) ? $urandom : freqs[ph]);
      cfg_write(CFG_BUF_WORDS, (ph % 2) ? 32'($urandom_range(1, 40))
                                        : 32'($urandom_range(1, 1048576)));
      for (int i = 0; i < 8; i++) rand_req();
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 6; i++) send_req(REQ_ENTER, rand64(), rand64(), 64'(i * 3), 7'd0);
    send_req(REQ_UNWIND, '0, '0, 64'd99, 7'd0);
    for (int i = 0; i < 4; i++) rand_req();
    wait_idle();
    cfg_write(CFG_ENABLE, 32'd0);
    send_req(REQ_RETURN, '0, '0, 64'd1, 7'd0);
    wait_idle();
  endtask

  initial begin
    int drain;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.pc = '0;
    in_ch.return_addr_in = '0;
    in_ch.timestamp = '0;
    in_ch.target_depth = '0;
    out_ch.ready = 1'b0;
    trc_enable = 1'b0;
    trc_buf_words = '0;
    trc_freq = 32'd1;
    trc_depth = '0;
    trc_ring = '0;
    trc_ovf = 1'b0;
    errors = 0;
    n_requests = 0;
    n_checked = 0;
    n_writes = 0;
    burst_left = 0;
    hold_cycles = 0;
    stall_cyc = 0;
    now_ts = 64'd1000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled();
    test_directed();
    test_full_depth();
    test_shrunk_ring();
    test_random();
    test_backpressure();

    drain = 0;
    while (pending_results.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    if (pending_results.size() != 0) begin
      report("results never arrived", 64'd0, 64'(pending_results.size()));
    end
    $display("tb: %0d requests sent, %0d results checked, %0d trace writes predicted",
             n_requests, n_checked, n_writes);
    $display("tb: covered disabled, full depth, ring wrap and shrink, divide extremes");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
